// ===== rtl/decimal_number_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Decimal number parser assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NUMBER_PARSER_CORE_MACROS_SVH
`define DECIMAL_NUMBER_PARSER_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define DNP_ASSERT_ON(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dnp assertion failed");

// Check a property on every clock edge, reset included.
`define DNP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("dnp assertion failed");

`endif

// ===== rtl/dnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser package
// Types, character codes and limits shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dnp_pkg;

  localparam int unsigned CharW       = 16;
  localparam int unsigned MantissaW   = 64;
  localparam int unsigned FracW       = 7;
  localparam int unsigned MantWidthDef = 64;

  localparam logic [CharW-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CharW-1:0] CH_NINE  = 16'h0039;
  localparam logic [CharW-1:0] CH_POINT = 16'h002E;
  localparam logic [CharW-1:0] CH_MINUS = 16'h002D;
  localparam logic [CharW-1:0] CH_PLUS  = 16'h002B;

  localparam logic [FracW-1:0] FRAC_MAX = 7'd127;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_INT   = 4'b0010,
    PH_POINT = 4'b0100,
    PH_FRAC  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             is_last;
    logic             no_char;
  } item_t;

  typedef struct packed {
    logic                 valid_res;
    logic                 negative;
    logic [MantissaW-1:0] mantissa;
    logic [FracW-1:0]     fraction_digits;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dnp_if.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser channels
// Valid/ready interfaces for the character and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] character;
  logic        is_last;
  logic        no_char;

  modport source (output valid, output character, output is_last, output no_char,
                  input ready);
  modport sink   (input valid, input character, input is_last, input no_char,
                  output ready);
endinterface

interface dnp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic        negative;
  logic [63:0] mantissa;
  logic [6:0]  fraction_digits;

  modport source (output valid, output valid_res, output negative, output mantissa,
                  output fraction_digits, input ready);
  modport sink   (input valid, input valid_res, input negative, input mantissa,
                  input fraction_digits, output ready);
endinterface

`default_nettype wire

// ===== rtl/decimal_number_parser_core.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser core
// Parses a signed decimal number from a stream of UTF-16 code units.
//
// Usage:
//   in_i carries one code unit per transfer with is_last marking the end of
//   the string; no_char set means the transfer carries no character and only
//   closes (or pads) the string. out_o delivers one result per string on the
//   transfer that carries is_last: valid_res, negative, the mantissa holding
//   all digits, and the fraction digit count (saturating at 127). An invalid
//   string reports all other fields as zero.
//   The result of the closing input transfer passes the input register,
//   then the result register, before it shows on out_o.
//   Throughput: one character per cycle unless the input stalls, set by the
//   combinational multiply-by-ten shift-add feeding the accumulator register.
//   Reset clears the parse state and the valid flags of both stages; the
//   first string starts right after reset is released.
//   When the receiver holds ready low, the result is held; the input keeps
//   taking characters that do not close a string, and stalls on a closing
//   transfer until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_number_parser_core #(
  parameter int unsigned MANTISSA_WIDTH = dnp_pkg::MantWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dnp_in_if.sink    in_i,
  dnp_out_if.source out_o
);
  import dnp_pkg::*;

  logic    in_vld, out_free, fire, load;
  item_t   item;
  result_t result;

  assign fire = in_vld && (!item.is_last || out_free);
  assign load = fire && item.is_last;

  dnp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (fire),
    .vld_o     (in_vld),
    .item_o    (item)
  );

  dnp_step #(
    .MantissaWidth (MANTISSA_WIDTH)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  dnp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .out_o    (out_o),
    .load_i   (load),
    .result_i (result),
    .free_o   (out_free)
  );

endmodule

`default_nettype wire

// ===== rtl/dnp_in_stage.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser input stage
// Registers one character transfer ahead of the parse step.
// ----------------------------------------------------------------------------
`default_nettype none

module dnp_in_stage (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dnp_in_if.sink      in_i,
  input  wire logic   advance_i,
  output logic        vld_o,
  output dnp_pkg::item_t item_o
);
  import dnp_pkg::*;

  logic  vld_q;
  item_t item_q;

  assign in_i.ready = !vld_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.character <= in_i.character;
      item_q.is_last   <= in_i.is_last;
      item_q.no_char   <= in_i.no_char;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

// ===== rtl/dnp_step.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser step
// Holds the parse state and applies one character per cycle when fire_i is set.
// ----------------------------------------------------------------------------
`default_nettype none

module dnp_step #(
  parameter int unsigned MantissaWidth = dnp_pkg::MantWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire dnp_pkg::item_t  item_i,
  output dnp_pkg::result_t     result_o
);
  import dnp_pkg::*;

  localparam int unsigned ProdW = MantissaWidth + 4;

  phase_e                   phase_q, phase_d, phase_n;
  logic                     failed_q, failed_d;
  logic                     minus_q, minus_d;
  logic [MantissaWidth-1:0] acc_q, acc_d;
  logic [FracW-1:0]         frac_q, frac_d;

  logic             is_digit, is_point, is_plus, is_minus, take, ovf, ok;
  logic [ProdW-1:0] acc_ext, prod;

  assign is_digit = (item_i.character >= CH_ZERO) && (item_i.character <= CH_NINE);
  assign is_point = item_i.character == CH_POINT;
  assign is_plus  = item_i.character == CH_PLUS;
  assign is_minus = item_i.character == CH_MINUS;
  assign take     = !item_i.no_char && !failed_q;

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
  assign acc_ext = {4'b0000, acc_q};
  assign prod    = (acc_ext << 3) + (acc_ext << 1)
                 + {{(ProdW-4){1'b0}}, item_i.character[3:0]};
  assign ovf     = |prod[ProdW-1:MantissaWidth];

  always_comb begin
    phase_d  = phase_q;
    failed_d = failed_q;
    minus_d  = minus_q;
    acc_d    = acc_q;
    frac_d   = frac_q;
    if (take) begin
      unique case (phase_q)
        PH_START: begin
          if (is_plus) begin
            phase_d = PH_INT;
          end else if (is_minus) begin
            minus_d = 1'b1;
            phase_d = PH_INT;
          end else if (is_digit) begin
            acc_d   = prod[MantissaWidth-1:0];
            phase_d = PH_INT;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            if (ovf) begin
              failed_d = 1'b1;
            end else begin
              acc_d = prod[MantissaWidth-1:0];
            end
          end else if (is_point) begin
            phase_d = PH_POINT;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_POINT, PH_FRAC: begin
          if (!is_digit || ovf) begin
            failed_d = 1'b1;
          end else begin
            acc_d   = prod[MantissaWidth-1:0];
            phase_d = PH_FRAC;
            if (frac_q != FRAC_MAX) begin
              frac_d = frac_q + 7'd1;
            end
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end
  end

  assign ok = !failed_d && (phase_d != PH_POINT);

  always_comb begin
    result_o.valid_res       = ok;
    result_o.negative        = ok && minus_d;
    result_o.mantissa        = ok ? {{(MantissaW-MantissaWidth){1'b0}}, acc_d}
                                  : '0;
    result_o.fraction_digits = ok ? frac_d : '0;
  end

  // drop back to the start state after the closing transfer
  assign phase_n = item_i.is_last ? PH_START : phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      failed_q <= 1'b0;
      minus_q  <= 1'b0;
      acc_q    <= '0;
      frac_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_n;
      failed_q <= item_i.is_last ? 1'b0 : failed_d;
      minus_q  <= item_i.is_last ? 1'b0 : minus_d;
      acc_q    <= item_i.is_last ? '0 : acc_d;
      frac_q   <= item_i.is_last ? '0 : frac_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dnp_out_stage.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser output stage
// Result register that drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dnp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  dnp_out_if.source             out_o,
  input  wire logic             load_i,
  input  wire dnp_pkg::result_t result_i,
  output logic                  free_o
);
  import dnp_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign free_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid           = vld_q;
  assign out_o.valid_res       = res_q.valid_res;
  assign out_o.negative        = res_q.negative;
  assign out_o.mantissa        = res_q.mantissa;
  assign out_o.fraction_digits = res_q.fraction_digits;

endmodule

`default_nettype wire

// ===== rtl/dnp_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal number parser checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_number_parser_core_macros.svh"

module dnp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic        valid_res_i,
  input wire logic        negative_i,
  input wire logic [63:0] mantissa_i,
  input wire logic [6:0]  frac_i
);

  logic res_zero;

  assign res_zero = !negative_i && (mantissa_i == 64'd0) && (frac_i == 7'd0);

  `DNP_ASSERT_ON(a_out_hold, valid_i && !ready_i |=> valid_i && $stable(mantissa_i))

  `DNP_ASSERT_ON(a_invalid_zero, valid_i && !valid_res_i |-> res_zero)

  `DNP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !valid_i)

endmodule

bind decimal_number_parser_core dnp_checker u_dnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (out_o.valid),
  .ready_i     (out_o.ready),
  .valid_res_i (out_o.valid_res),
  .negative_i  (out_o.negative),
  .mantissa_i  (out_o.mantissa),
  .frac_i      (out_o.fraction_digits)
);

`default_nettype wire
